@@ design/mesh_surface_area_unit_macros.svh @@
// Assertion macros for the mesh surface area checker.
// Depends on: nothing; users supply clk and rst_n in scope.
`ifndef MESH_SURFACE_AREA_UNIT_MACROS_SVH
`define MESH_SURFACE_AREA_UNIT_MACROS_SVH

// Checked only outside reset.
`define MSA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define MSA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/msa_pkg.sv @@
// Shared types and constants for the mesh surface area unit.
// Depends on: nothing.
`timescale 1ns / 1ps

package msa_pkg;

    localparam int COORD_BITS  = 16;
    localparam int DIFF_BITS   = COORD_BITS + 1;       // edge vector component
    localparam int MUL_BITS    = 18;                   // shared multiplier operand
    localparam int PROD_BITS   = 2 * MUL_BITS;
    localparam int DET_BITS    = 2 * DIFF_BITS + 1;    // projected determinant
    localparam int LO_BITS     = 17;                   // low half of a determinant
    localparam int SQ_BITS     = 68;                   // sum of squares
    localparam int SQACC_BITS  = SQ_BITS + 3;          // signed partial sums
    localparam int ROOT_BITS   = SQ_BITS / 2;
    localparam int ROOT_STEPS  = ROOT_BITS;
    localparam int ROOT_CNT_BITS = $clog2(ROOT_STEPS);
    localparam int REM_BITS    = ROOT_BITS + 2;
    localparam int AREA_BITS   = 33;
    localparam int ACCUM_BITS  = 48;
    localparam int SUM_BITS    = ACCUM_BITS + 1;

    localparam logic [ACCUM_BITS-1:0] ACC_MAX = {ACCUM_BITS{1'b1}};

    // phases of one plane in the product sequencer
    localparam logic [2:0] PH_FIRST  = 3'd0;
    localparam logic [2:0] PH_SECOND = 3'd1;
    localparam logic [2:0] PH_SUB    = 3'd2;
    localparam logic [2:0] PH_LL     = 3'd3;
    localparam logic [2:0] PH_HL     = 3'd4;
    localparam logic [2:0] PH_HH     = 3'd5;

    // what to do with the registered product in the next cycle
    localparam logic [2:0] CON_NONE = 3'd0;
    localparam logic [2:0] CON_LOAD = 3'd1;
    localparam logic [2:0] CON_SUB  = 3'd2;
    localparam logic [2:0] CON_LL   = 3'd3;
    localparam logic [2:0] CON_HL   = 3'd4;
    localparam logic [2:0] CON_HH   = 3'd5;

    localparam logic [1:0] PLANE_XY = 2'd0;
    localparam logic [1:0] PLANE_YZ = 2'd1;
    localparam logic [1:0] PLANE_ZX = 2'd2;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_BITS-1:0]  diff_t;
    typedef logic signed [MUL_BITS-1:0]   mul_op_t;
    typedef logic signed [PROD_BITS-1:0]  prod_t;

    // edge vectors u = b - a, v = c - a
    typedef struct packed {
        diff_t ux;
        diff_t uy;
        diff_t uz;
        diff_t vx;
        diff_t vy;
        diff_t vz;
    } edges_t;

    typedef struct packed {
        logic               done;
        logic [SQ_BITS-1:0] sum_sq;
    } sq_result_t;

    typedef struct packed {
        logic                 done;
        logic [ROOT_BITS-1:0] root;
    } root_result_t;

endpackage

@@ design/msa_if.sv @@
// Request and result channel interfaces of the mesh surface area unit.
// Depends on: msa_pkg.
`timescale 1ns / 1ps

interface msa_in_if;
    logic            valid;
    logic            ready;
    msa_pkg::coord_t ax;
    msa_pkg::coord_t ay;
    msa_pkg::coord_t az;
    msa_pkg::coord_t bx;
    msa_pkg::coord_t by;
    msa_pkg::coord_t bz;
    msa_pkg::coord_t cx;
    msa_pkg::coord_t cy;
    msa_pkg::coord_t cz;
    logic            last_triangle;

    modport source (output valid, ax, ay, az, bx, by, bz, cx, cy, cz, last_triangle,
                    input ready);
    modport sink   (input valid, ax, ay, az, bx, by, bz, cx, cy, cz, last_triangle,
                    output ready);
endinterface

interface msa_out_if;
    logic                               valid;
    logic                               ready;
    logic [msa_pkg::AREA_BITS-1:0]      triangle_area;
    logic [msa_pkg::ACCUM_BITS-1:0]     total_area;
    logic                               total_saturated;
    logic                               mesh_done;

    modport source (output valid, triangle_area, total_area, total_saturated, mesh_done,
                    input ready);
    modport sink   (input valid, triangle_area, total_area, total_saturated, mesh_done,
                    output ready);
endinterface

@@ design/msa_mul.sv @@
// Shared signed 18x18 multiplier with registered product.
// Depends on: msa_pkg.
`timescale 1ns / 1ps

module msa_mul
(
    input  logic             clk,
    input  msa_pkg::mul_op_t a,
    input  msa_pkg::mul_op_t b,
    output msa_pkg::prod_t   prod
);

    msa_pkg::prod_t prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

@@ design/msa_cross.sv @@
// Product sequencer: three projected determinants and the sum of their
// squares on one shared multiplier. Depends on: msa_pkg, msa_mul.
`timescale 1ns / 1ps

module msa_cross
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  msa_pkg::edges_t     edges,
    output msa_pkg::sq_result_t res
);

    logic       run_reg,   run_next;
    logic       drain_reg, drain_next;
    logic       done_reg,  done_next;
    logic [1:0] plane_reg, plane_next;
    logic [2:0] phase_reg, phase_next;
    logic [2:0] cons_reg,  cons_next;

    logic signed [msa_pkg::DET_BITS-1:0]   det_reg, det_next;
    logic signed [msa_pkg::SQACC_BITS-1:0] acc_reg, acc_next;

    msa_pkg::diff_t   p_a1, p_b1, p_a2, p_b2;
    msa_pkg::mul_op_t op_a, op_b, det_hi, det_lo;
    msa_pkg::prod_t   prod;

    msa_mul u_mul
    (
        .clk  (clk),
        .a    (op_a),
        .b    (op_b),
        .prod (prod)
    );

    // det = a1*b1 - a2*b2 for the current plane
    always_comb
    begin
        case (plane_reg)
            msa_pkg::PLANE_XY:
            begin
                p_a1 = edges.ux; p_b1 = edges.vy; p_a2 = edges.vx; p_b2 = edges.uy;
            end
            msa_pkg::PLANE_YZ:
            begin
                p_a1 = edges.uy; p_b1 = edges.vz; p_a2 = edges.vy; p_b2 = edges.uz;
            end
            msa_pkg::PLANE_ZX:
            begin
                p_a1 = edges.uz; p_b1 = edges.vx; p_a2 = edges.vz; p_b2 = edges.ux;
            end
            default:
            begin
                p_a1 = edges.ux; p_b1 = edges.vy; p_a2 = edges.vx; p_b2 = edges.uy;
            end
        endcase
    end

    // det = hi * 2^17 + lo, hi signed, lo unsigned
    assign det_hi = det_reg[msa_pkg::DET_BITS-1:msa_pkg::LO_BITS];
    assign det_lo = $signed({1'b0, det_reg[msa_pkg::LO_BITS-1:0]});

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        cons_next = msa_pkg::CON_NONE;
        if (run_reg)
        begin
            case (phase_reg)
                msa_pkg::PH_FIRST:
                begin
                    op_a = msa_pkg::mul_op_t'(p_a1);
                    op_b = msa_pkg::mul_op_t'(p_b1);
                    cons_next = msa_pkg::CON_LOAD;
                end
                msa_pkg::PH_SECOND:
                begin
                    op_a = msa_pkg::mul_op_t'(p_a2);
                    op_b = msa_pkg::mul_op_t'(p_b2);
                    cons_next = msa_pkg::CON_SUB;
                end
                msa_pkg::PH_LL:
                begin
                    op_a = det_lo;
                    op_b = det_lo;
                    cons_next = msa_pkg::CON_LL;
                end
                msa_pkg::PH_HL:
                begin
                    op_a = det_hi;
                    op_b = det_lo;
                    cons_next = msa_pkg::CON_HL;
                end
                msa_pkg::PH_HH:
                begin
                    op_a = det_hi;
                    op_b = det_hi;
                    cons_next = msa_pkg::CON_HH;
                end
                default:
                begin
                    cons_next = msa_pkg::CON_NONE;   // subtract slot, multiplier idle
                end
            endcase
        end
    end

    // consume the product issued in the previous cycle
    always_comb
    begin
        det_next = det_reg;
        acc_next = acc_reg;
        case (cons_reg)
            msa_pkg::CON_LOAD: det_next = msa_pkg::DET_BITS'(prod);
            msa_pkg::CON_SUB:  det_next = det_reg - msa_pkg::DET_BITS'(prod);
            msa_pkg::CON_LL:   acc_next = acc_reg + msa_pkg::SQACC_BITS'(prod);
            msa_pkg::CON_HL:   acc_next = acc_reg + (msa_pkg::SQACC_BITS'(prod) <<< 18);
            msa_pkg::CON_HH:   acc_next = acc_reg + (msa_pkg::SQACC_BITS'(prod) <<< 34);
            default:           acc_next = acc_reg;
        endcase
        if (start)
        begin
            acc_next = '0;
        end
    end

    always_comb
    begin
        run_next   = run_reg;
        plane_next = plane_reg;
        phase_next = phase_reg;
        drain_next = 1'b0;
        done_next  = drain_reg;
        if (start)
        begin
            run_next   = 1'b1;
            plane_next = msa_pkg::PLANE_XY;
            phase_next = msa_pkg::PH_FIRST;
        end
        else if (run_reg)
        begin
            if (phase_reg == msa_pkg::PH_HH)
            begin
                phase_next = msa_pkg::PH_FIRST;
                if (plane_reg == msa_pkg::PLANE_ZX)
                begin
                    run_next   = 1'b0;
                    drain_next = 1'b1;
                end
                else
                begin
                    plane_next = plane_reg + 2'd1;
                end
            end
            else
            begin
                phase_next = phase_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            drain_reg <= 1'b0;
            done_reg  <= 1'b0;
            plane_reg <= msa_pkg::PLANE_XY;
            phase_reg <= msa_pkg::PH_FIRST;
            cons_reg  <= msa_pkg::CON_NONE;
        end
        else
        begin
            run_reg   <= run_next;
            drain_reg <= drain_next;
            done_reg  <= done_next;
            plane_reg <= plane_next;
            phase_reg <= phase_next;
            cons_reg  <= cons_next;
        end
    end

    always_ff @(posedge clk)
    begin
        det_reg <= det_next;
        acc_reg <= acc_next;
    end

    // final sum is non-negative and below 2^68
    assign res.done   = done_reg;
    assign res.sum_sq = acc_reg[msa_pkg::SQ_BITS-1:0];

endmodule

@@ design/msa_root.sv @@
// Bitwise integer square root, two radicand bits per cycle.
// Depends on: msa_pkg.
`timescale 1ns / 1ps

module msa_root
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [msa_pkg::SQ_BITS-1:0]   radicand,
    output msa_pkg::root_result_t         res
);

    logic                                run_reg,  run_next;
    logic                                done_reg, done_next;
    logic [msa_pkg::ROOT_CNT_BITS-1:0]   cnt_reg,  cnt_next;
    logic [msa_pkg::SQ_BITS-1:0]         rad_reg,  rad_next;
    logic [msa_pkg::REM_BITS-3:0]        rem_reg,  rem_next;
    logic [msa_pkg::ROOT_BITS-1:0]       root_reg, root_next;

    logic [msa_pkg::REM_BITS-1:0] rem_sh, trial, rem_sub;
    logic                         fits;

    assign rem_sh  = {rem_reg, rad_reg[msa_pkg::SQ_BITS-1 -: 2]};
    assign trial   = {root_reg, 2'b01};
    assign fits    = rem_sh >= trial;
    assign rem_sub = rem_sh - trial;

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            run_next  = 1'b1;
            cnt_next  = '0;
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (run_reg)
        begin
            rad_next = rad_reg << 2;
            if (fits)
            begin
                rem_next  = rem_sub[msa_pkg::REM_BITS-3:0];
                root_next = {root_reg[msa_pkg::ROOT_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh[msa_pkg::REM_BITS-3:0];
                root_next = {root_reg[msa_pkg::ROOT_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == msa_pkg::ROOT_CNT_BITS'(msa_pkg::ROOT_STEPS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign res.done = done_reg;
    assign res.root = root_reg;

endmodule

@@ design/mesh_surface_area_unit.sv @@
// Mesh surface area unit: one triangle per request, area and running total.
// A triangle takes 18 multiplier slots on the shared 18x18 multiplier plus
// 34 steps of the bitwise square root, and its result then waits for a free
// output register. Not ready while a triangle is in work.
// Reset (async, active low) clears the running total, the saturation flag and
// all handshake state. Depends on: msa_pkg, msa_if, msa_cross, msa_root.
`timescale 1ns / 1ps

module mesh_surface_area_unit
(
    input  logic      clk,
    input  logic      rst_n,
    msa_in_if.sink    triangle,
    msa_out_if.source result
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SQ   = 2'd1;   // determinants and squares
    localparam logic [1:0] ST_ROOT = 2'd2;   // square root
    localparam logic [1:0] ST_FIN  = 2'd3;   // accumulate and publish

    logic [1:0] state_reg, state_next;
    logic       start_reg, start_next;
    logic       last_reg;
    logic       sat_reg,   sat_next;
    logic [msa_pkg::ACCUM_BITS-1:0] acc_reg, acc_next;

    logic                           out_valid_reg, out_valid_next;
    logic [msa_pkg::AREA_BITS-1:0]  area_out_reg;
    logic [msa_pkg::ACCUM_BITS-1:0] total_out_reg;
    logic                           sat_out_reg;
    logic                           done_out_reg;

    msa_pkg::edges_t      edges_reg;
    msa_pkg::sq_result_t  sq_res;
    msa_pkg::root_result_t root_res;

    logic                           accept;
    logic                           fin_go;
    logic [msa_pkg::AREA_BITS-1:0]  area;
    logic [msa_pkg::SUM_BITS-1:0]   sum;
    logic                           hit;
    logic [msa_pkg::ACCUM_BITS-1:0] total;
    logic                           sat_new;

    assign triangle.ready = (state_reg == ST_IDLE);
    assign accept         = triangle.valid && triangle.ready;

    msa_cross u_cross
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .edges (edges_reg),
        .res   (sq_res)
    );

    // root starts on the cycle the sum of squares is final
    msa_root u_root
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_res.done),
        .radicand (sq_res.sum_sq),
        .res      (root_res)
    );

    // root < 2^34, so half of it always fits the 33-bit area field
    assign area    = root_res.root[msa_pkg::ROOT_BITS-1:1];
    assign sum     = msa_pkg::SUM_BITS'(acc_reg) + msa_pkg::SUM_BITS'(area);
    assign hit     = sum >= msa_pkg::SUM_BITS'(msa_pkg::ACC_MAX);
    assign total   = hit ? msa_pkg::ACC_MAX : sum[msa_pkg::ACCUM_BITS-1:0];
    assign sat_new = sat_reg | hit;

    // publish only into a free (or draining) output register
    assign fin_go = (state_reg == ST_FIN) && (!out_valid_reg || result.ready);

    always_comb
    begin
        state_next     = state_reg;
        start_next     = 1'b0;
        acc_next       = acc_reg;
        sat_next       = sat_reg;
        out_valid_next = out_valid_reg && !result.ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SQ;
                    start_next = 1'b1;
                end
            end
            ST_SQ:
            begin
                if (sq_res.done)
                begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (root_res.done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (fin_go)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    // end of mesh: report this total, then start afresh
                    acc_next = last_reg ? '0 : total;
                    sat_next = last_reg ? 1'b0 : sat_new;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            acc_reg       <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            acc_reg       <= acc_next;
            sat_reg       <= sat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // edge vectors formed once per request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            edges_reg.ux <= msa_pkg::diff_t'(triangle.bx) - msa_pkg::diff_t'(triangle.ax);
            edges_reg.uy <= msa_pkg::diff_t'(triangle.by) - msa_pkg::diff_t'(triangle.ay);
            edges_reg.uz <= msa_pkg::diff_t'(triangle.bz) - msa_pkg::diff_t'(triangle.az);
            edges_reg.vx <= msa_pkg::diff_t'(triangle.cx) - msa_pkg::diff_t'(triangle.ax);
            edges_reg.vy <= msa_pkg::diff_t'(triangle.cy) - msa_pkg::diff_t'(triangle.ay);
            edges_reg.vz <= msa_pkg::diff_t'(triangle.cz) - msa_pkg::diff_t'(triangle.az);
            last_reg     <= triangle.last_triangle;
        end
        if (fin_go)
        begin
            area_out_reg  <= area;
            total_out_reg <= total;
            sat_out_reg   <= sat_new;
            done_out_reg  <= last_reg;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.triangle_area   = area_out_reg;
    assign result.total_area      = total_out_reg;
    assign result.total_saturated = sat_out_reg;
    assign result.mesh_done       = done_out_reg;

endmodule

@@ design/msa_check.sv @@
// Port-level checker for the mesh surface area unit, bound to the top level.
// Depends on: msa_pkg, mesh_surface_area_unit_macros.svh.
`timescale 1ns / 1ps
`include "mesh_surface_area_unit_macros.svh"

module msa_check
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [msa_pkg::AREA_BITS-1:0]  triangle_area,
    input logic [msa_pkg::ACCUM_BITS-1:0] total_area,
    input logic                           total_saturated
);

    `MSA_ASSERT(a_busy_after_request, in_valid && in_ready |=> !in_ready, "ready after request")
    `MSA_ASSERT(a_result_held, out_valid && !out_ready |=> out_valid && $stable(total_area), "result dropped")
    `MSA_ASSERT(a_total_covers_area, out_valid |-> total_area >= msa_pkg::ACCUM_BITS'(triangle_area), "total below area")
    `MSA_ASSERT(a_sat_at_max, out_valid && total_saturated |-> total_area == msa_pkg::ACC_MAX, "saturated total not max")
    // a clock edge in reset clears the output register by the next edge
    `MSA_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid, "result during reset")

endmodule

bind mesh_surface_area_unit msa_check u_msa_check
(
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (triangle.valid),
    .in_ready        (triangle.ready),
    .out_valid       (result.valid),
    .out_ready       (result.ready),
    .triangle_area   (result.triangle_area),
    .total_area      (result.total_area),
    .total_saturated (result.total_saturated)
);
